@@ sv/sfp_pkg.sv @@
// shared types and constants for the settings frame parser
// no dependencies

package sfp_pkg;

   localparam int unsigned ByteW  = 8;
   localparam int unsigned AccW   = 16;
   localparam int unsigned PerW   = 10;
   localparam int unsigned SenseW = 2;
   localparam int unsigned RspW   = 40;

   localparam logic [ByteW-1:0] ChNul   = 8'd0;
   localparam logic [ByteW-1:0] ChHash  = 8'd35;
   localparam logic [ByteW-1:0] ChComma = 8'd44;
   localparam logic [ByteW-1:0] ChZero  = 8'd48;

   localparam logic [AccW-1:0]   LimitPeriod      = 16'd512;
   localparam logic [AccW-1:0]   MaxSenseAcc      = 16'd3;
   localparam logic [PerW-1:0]   DfltSamples      = 10'd100;
   localparam logic [SenseW-1:0] MaxSense         = 2'd3;
   localparam logic [PerW-1:0]   DfltSamplePeriod = 10'd50;
   localparam logic [PerW-1:0]   DfltCalibPeriod  = 10'd250;

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_A    = 3'd1,
      PH_B    = 3'd2,
      PH_C    = 3'd3,
      PH_D    = 3'd4,
      PH_E    = 3'd5,
      PH_DONE = 3'd6
   } phase_type;

   typedef struct packed {
      logic              calibrate;
      logic [PerW-1:0]   calib_period;
      logic [PerW-1:0]   sample_period;
      logic [SenseW-1:0] sense_enable_code;
      logic [PerW-1:0]   samples_per_temp;
      logic              ok;
   } result_type;

endpackage

@@ sv/settings_frame_parser.sv @@
// Settings frame parser: takes one byte of a NUL-terminated "#a,b,c,d,e#" message per
// word and gives one result word per message, success at the closing '#' or failure when
// NUL comes first. Bytes are decoded combinationally, so one word can be accepted each
// clock while req_tready is high; a result goes into the result register (rsp_), or into
// the skid register while that one waits. This two-word output buffer lets input continue
// while a result waits; req_tready drops only while both are full. Depends on sfp_pkg.

module settings_frame_parser
   import sfp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  logic [7:0]      req_tdata,   // [7:0] rx_byte
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   output logic [RspW-1:0] rsp_tdata    // [0] ok, [10:1] samples_per_temp,
                                        // [12:11] sense_enable_code, [22:13] sample_period,
                                        // [32:23] calib_period, [33] calibrate, [39:34] zero
);

   phase_type         phase_ff, phase_in;
   logic [AccW-1:0]   accum_ff, accum_in;
   logic [PerW-1:0]   samples_ff, samples_in;
   logic [SenseW-1:0] sense_ff, sense_in;
   logic [PerW-1:0]   sample_period_ff, sample_period_in;
   logic [PerW-1:0]   calib_period_ff, calib_period_in;
   logic              calibrate_ff, calibrate_in;

   logic              out_valid_ff, out_valid_in;
   logic              skid_valid_ff, skid_valid_in;
   result_type        out_ff, out_in;
   result_type        skid_ff, skid_in;

   logic              byte_accept;
   logic              emit;
   logic              emit_ok;
   logic              closing;
   logic              out_take;
   logic [AccW-1:0]   accum_next_digit;
   logic [ByteW-1:0]   rx_byte;
   result_type        result;

   assign rx_byte     = req_tdata[ByteW-1:0];
   assign req_tready  = !skid_valid_ff;
   assign byte_accept = req_tvalid && req_tready;
   assign out_take    = out_valid_ff && rsp_tready;

   // acc*10 + byte - '0', wrapping
   assign accum_next_digit = (accum_ff << 3) + (accum_ff << 1)
                           + {{(AccW-ByteW){1'b0}}, rx_byte}
                           - {{(AccW-ByteW){1'b0}}, ChZero};

   assign closing = ((phase_ff != PH_E) && (rx_byte == ChComma))
                 || ((phase_ff == PH_E) && (rx_byte == ChHash));

   always_comb begin
      phase_in         = phase_ff;
      accum_in         = accum_ff;
      samples_in       = samples_ff;
      sense_in         = sense_ff;
      sample_period_in = sample_period_ff;
      calib_period_in  = calib_period_ff;
      calibrate_in     = calibrate_ff;
      emit             = 1'b0;
      emit_ok          = 1'b0;
      case (phase_ff)
         PH_DONE: begin
            if (rx_byte == ChNul) begin
               phase_in = PH_IDLE;
            end
         end
         PH_A, PH_B, PH_C, PH_D, PH_E: begin
            if (rx_byte == ChNul) begin
               phase_in = PH_IDLE;
               emit     = 1'b1;
            end else if (closing) begin
               accum_in = '0;
               case (phase_ff)
                  PH_A: begin
                     samples_in = (accum_ff > LimitPeriod) ? DfltSamples : accum_ff[PerW-1:0];
                     phase_in   = PH_B;
                  end
                  PH_B: begin
                     sense_in = (accum_ff > MaxSenseAcc) ? MaxSense : accum_ff[SenseW-1:0];
                     phase_in = PH_C;
                  end
                  PH_C: begin
                     sample_period_in = (accum_ff > LimitPeriod) ? DfltSamplePeriod
                                                                 : accum_ff[PerW-1:0];
                     phase_in = PH_D;
                  end
                  PH_D: begin
                     calib_period_in = (accum_ff > LimitPeriod) ? DfltCalibPeriod
                                                                : accum_ff[PerW-1:0];
                     phase_in = PH_E;
                  end
                  default: begin
                     calibrate_in = (accum_ff == {{(AccW-1){1'b0}}, 1'b1});
                     phase_in     = PH_DONE;
                     emit         = 1'b1;
                     emit_ok      = 1'b1;
                  end
               endcase
            end else begin
               accum_in = accum_next_digit;
            end
         end
         default: begin
            phase_in = PH_IDLE;
            if (rx_byte == ChNul) begin
               emit = 1'b1;
            end else if (rx_byte == ChHash) begin
               phase_in = PH_A;
               accum_in = '0;
            end
         end
      endcase
   end

   always_comb begin
      result.ok                = emit_ok;
      result.samples_per_temp  = samples_in;
      result.sense_enable_code = sense_in;
      result.sample_period     = sample_period_in;
      result.calib_period      = calib_period_in;
      result.calibrate         = calibrate_in;
   end

   // result register with skid stage behind it
   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (!out_valid_ff || out_take) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else if (byte_accept && emit) begin
            out_in       = result;
            out_valid_in = 1'b1;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (byte_accept && emit) begin
         skid_in       = result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_IDLE;
         accum_ff         <= '0;
         samples_ff       <= '0;
         sense_ff         <= '0;
         sample_period_ff <= '0;
         calib_period_ff  <= '0;
         calibrate_ff     <= 1'b0;
         out_valid_ff     <= 1'b0;
         skid_valid_ff    <= 1'b0;
      end else begin
         if (byte_accept) begin
            phase_ff         <= phase_in;
            accum_ff         <= accum_in;
            samples_ff       <= samples_in;
            sense_ff         <= sense_in;
            sample_period_ff <= sample_period_in;
            calib_period_ff  <= calib_period_in;
            calibrate_ff     <= calibrate_in;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RspW-$bits(result_type)){1'b0}}, out_ff};

endmodule

@@ sv/sfp_checker.sv @@
// port-level checks for the settings frame parser
// depends on sfp_pkg; bound to settings_frame_parser

module sfp_checker
   import sfp_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_tvalid,
   input logic            req_tready,
   input logic            rsp_tvalid,
   input logic            rsp_tready,
   input logic [RspW-1:0] rsp_tdata
);

   // a stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   // nothing pending right after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // a result word only appears after an accepted byte
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid && !(req_tvalid && req_tready) |=> !rsp_tvalid)
      else $error("result word without an accepted byte");

   // the stored sample count and periods stay clamped and the padding stays zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[10:1] <= 10'd512) && (rsp_tdata[22:13] <= 10'd512)
                     && (rsp_tdata[32:23] <= 10'd512) && (rsp_tdata[39:34] == 6'd0))
      else $error("result field out of range");

endmodule

bind settings_frame_parser sfp_checker u_sfp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
